[rtl/core/i2ctbb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2ctbb_pkg
// Shared constants and types of the i2c target byte buffer.
// ----------------------------------------------------------------------------
package i2ctbb_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;

  localparam int MODE_W = 3;
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;

  // input event codes
  localparam logic [MODE_W-1:0] MODE_RECEIVE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TO_MASTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RX_BYTE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TX_DONE   = 2'd2;

  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_DONE    = 2'd2
  } cmd_op_t;

  localparam int OP_W = $bits(cmd_op_t);

endpackage
`default_nettype wire

[rtl/core/i2c_target_byte_buffer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_target_byte_buffer
// Byte buffering of an i2c target, one bus or host event per input transfer.
// ----------------------------------------------------------------------------
// Events enter on the slave stream (tuser = event code, tdata = byte, tlast =
// end of a host transmit load) and results leave on the master stream. A
// front stage updates indices and lengths and writes the receive and transmit
// stores; a short command queue hands result work to a back stage that reads
// the stores into a result register. Events that write no store (requests,
// stops and flushes) go in at one per cycle while the queue has room. A
// receive or load event waits until the back stage and queue are empty, since
// it writes a store that queued work may still read. A request answer reads
// the store when popped, then fills the result register; a stop after
// reception delivers its n bytes one per cycle from the receive store read
// port when the sink takes every transfer. Stores need no clearing after reset.
// ----------------------------------------------------------------------------
module i2c_target_byte_buffer #(
  parameter int BUFFER_DEPTH = i2ctbb_pkg::BUFFER_DEPTH_DEFAULT,
  parameter int QUEUE_DEPTH  = i2ctbb_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int LW       = $clog2(BUFFER_DEPTH + 1),
  localparam int OUT_BITS = i2ctbb_pkg::BYTE_W + LW + 1,
  localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [i2ctbb_pkg::BYTE_W-1:0]  s_axis_tdata,  // in_byte
  input  wire logic [i2ctbb_pkg::MODE_W-1:0]  s_axis_tuser,  // mode
  input  wire logic                           s_axis_tlast,  // load_last
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [TDATA_W-1:0]             m_axis_tdata,  // out_byte, run_length, busy_res
  output logic      [i2ctbb_pkg::KIND_W-1:0]  m_axis_tuser,  // kind
  output logic                                m_axis_tlast   // run_last
);

  import i2ctbb_pkg::*;

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int CMD_W = OP_W + 1 + LW;

  logic              back_idle;
  logic              queue_full;
  logic              queue_empty;
  logic              push;
  logic              pop;
  logic [CMD_W-1:0]  push_cmd;
  logic [CMD_W-1:0]  head;
  logic              rx_we;
  logic [AW-1:0]     rx_waddr;
  logic              tx_we;
  logic [AW-1:0]     tx_waddr;
  logic              rx_re;
  logic [AW-1:0]     rx_raddr;
  logic [BYTE_W-1:0] rx_rdata;
  logic              tx_re;
  logic [AW-1:0]     tx_raddr;
  logic [BYTE_W-1:0] tx_rdata;
  logic [BYTE_W-1:0] out_byte;
  logic [LW-1:0]     run_length;
  logic              busy_res;

  i2ctbb_front #(
    .DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .mode       (s_axis_tuser),
    .load_last  (s_axis_tlast),
    .back_idle  (back_idle),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .rx_we      (rx_we),
    .rx_waddr   (rx_waddr),
    .tx_we      (tx_we),
    .tx_waddr   (tx_waddr)
  );

  i2ctbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_rx_store (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (s_axis_tdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  i2ctbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_tx_store (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (s_axis_tdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  i2ctbb_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  i2ctbb_back #(
    .DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .idle        (back_idle),
    .tx_re       (tx_re),
    .tx_raddr    (tx_raddr),
    .tx_rdata    (tx_rdata),
    .rx_re       (rx_re),
    .rx_raddr    (rx_raddr),
    .rx_rdata    (rx_rdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .kind        (m_axis_tuser),
    .out_byte    (out_byte),
    .run_last    (m_axis_tlast),
    .run_length  (run_length),
    .busy_res    (busy_res)
  );

  assign m_axis_tdata = TDATA_W'({busy_res, run_length, out_byte});

endmodule
`default_nettype wire

[rtl/core/i2ctbb_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2ctbb_ram
// Generic one-write one-read ram with registered read data.
// ----------------------------------------------------------------------------
module i2ctbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/i2ctbb_cmd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2ctbb_cmd_fifo
// Short command queue between the front and the back, head shown directly.
// ----------------------------------------------------------------------------
module i2ctbb_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/i2ctbb_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2ctbb_front
// Takes bus and host events, keeps indices and lengths, writes the stores
// and queues the work that produces results.
// ----------------------------------------------------------------------------
module i2ctbb_front #(
  parameter int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH),
  localparam int LW    = $clog2(DEPTH + 1),
  localparam int CMD_W = i2ctbb_pkg::OP_W + 1 + LW
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [i2ctbb_pkg::MODE_W-1:0]   mode,
  input  wire logic                            load_last,
  input  wire logic                            back_idle,
  input  wire logic                            queue_full,
  output logic                                 push,
  output logic      [CMD_W-1:0]                push_cmd,
  output logic                                 rx_we,
  output logic      [AW-1:0]                   rx_waddr,
  output logic                                 tx_we,
  output logic      [AW-1:0]                   tx_waddr
);

  import i2ctbb_pkg::*;

  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic [LW-1:0] rx_index, rx_index_next;
  logic [LW-1:0] rx_length, rx_length_next;
  logic [LW-1:0] tx_index, tx_index_next;
  logic [LW-1:0] tx_length, tx_length_next;
  logic [LW-1:0] load_ptr, load_ptr_next;
  logic          receiving, receiving_next;

  logic          accept;
  logic          writes_store;
  logic [LW-1:0] rx_slot;
  logic [LW-1:0] tx_slot;
  logic [LW-1:0] tx_len_eff;
  logic          fill;
  logic          load_room;
  logic [LW-1:0] load_after;
  cmd_op_t       op;
  logic [LW-1:0] arg;

  // store writes need the back quiet so no queued read sees a newer byte
  assign writes_store = (mode == MODE_RECEIVE) || (mode == MODE_LOAD);
  assign in_ready     = !queue_full && (!writes_store || back_idle);
  assign accept       = in_valid && in_ready;

  assign rx_slot    = (rx_index >= DEPTH_L) ? '0 : rx_index;
  assign tx_slot    = (tx_index >= DEPTH_L) ? '0 : tx_index;
  assign tx_len_eff = (tx_index >= DEPTH_L) ? '0 : tx_length;
  assign fill       = (tx_slot >= tx_len_eff);
  assign load_room  = (load_ptr < DEPTH_L);
  assign load_after = load_room ? load_ptr + LW'(1) : load_ptr;

  // the byte itself goes straight to both store write ports from the top
  assign rx_waddr = rx_slot[AW-1:0];
  assign tx_waddr = load_ptr[AW-1:0];
  assign push_cmd = {op, fill, arg};

  always_comb begin
    rx_index_next  = rx_index;
    rx_length_next = rx_length;
    tx_index_next  = tx_index;
    tx_length_next = tx_length;
    load_ptr_next  = load_ptr;
    receiving_next = receiving;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    push           = 1'b0;
    op             = OP_DONE;
    arg            = '0;
    if (accept) begin
      case (mode)
        MODE_RECEIVE: begin
          rx_we          = 1'b1;
          rx_index_next  = rx_slot + LW'(1);
          rx_length_next = rx_slot + LW'(1);
          receiving_next = 1'b1;
        end
        MODE_REQUEST: begin
          push           = 1'b1;
          op             = OP_REQUEST;
          arg            = tx_slot;
          tx_index_next  = tx_slot + LW'(1);
          tx_length_next = tx_len_eff;
          receiving_next = 1'b0;
        end
        MODE_STOP: begin
          if (receiving) begin
            if (rx_length != '0) begin
              push           = 1'b1;
              op             = OP_DRAIN;
              arg            = rx_length;
              rx_index_next  = '0;
              rx_length_next = '0;
            end
          end else if (tx_index >= tx_length) begin
            push = 1'b1;
            op   = OP_DONE;
          end
        end
        MODE_LOAD: begin
          tx_we = load_room;
          if (load_last) begin
            tx_length_next = load_after;
            tx_index_next  = '0;
            load_ptr_next  = '0;
          end else begin
            load_ptr_next = load_after;
          end
        end
        MODE_FLUSH: begin
          tx_length_next = '0;
          tx_index_next  = '0;
          load_ptr_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_index  <= '0;
      rx_length <= '0;
      tx_index  <= '0;
      tx_length <= '0;
      load_ptr  <= '0;
      receiving <= 1'b0;
    end else begin
      rx_index  <= rx_index_next;
      rx_length <= rx_length_next;
      tx_index  <= tx_index_next;
      tx_length <= tx_length_next;
      load_ptr  <= load_ptr_next;
      receiving <= receiving_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/i2ctbb_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2ctbb_back
// Carries out queued work: reads the stores and fills the result register.
// ----------------------------------------------------------------------------
module i2ctbb_back #(
  parameter int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH),
  localparam int LW    = $clog2(DEPTH + 1),
  localparam int CMD_W = i2ctbb_pkg::OP_W + 1 + LW
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            queue_empty,
  input  wire logic [CMD_W-1:0]                head,
  output logic                                 pop,
  output logic                                 idle,
  output logic                                 tx_re,
  output logic      [AW-1:0]                   tx_raddr,
  input  wire logic [i2ctbb_pkg::BYTE_W-1:0]   tx_rdata,
  output logic                                 rx_re,
  output logic      [AW-1:0]                   rx_raddr,
  input  wire logic [i2ctbb_pkg::BYTE_W-1:0]   rx_rdata,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [i2ctbb_pkg::KIND_W-1:0]   kind,
  output logic      [i2ctbb_pkg::BYTE_W-1:0]   out_byte,
  output logic                                 run_last,
  output logic      [LW-1:0]                   run_length,
  output logic                                 busy_res
);

  import i2ctbb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  back_state_t   state;
  cmd_op_t       op;
  logic          fill;
  logic [LW-1:0] len;
  logic [LW-1:0] cnt;

  cmd_op_t       head_op;
  logic          head_fill;
  logic [LW-1:0] head_arg;
  logic          slot_free;
  logic          emit;
  logic [LW-1:0] cnt_inc;
  logic          more;

  assign head_op   = cmd_op_t'(head[CMD_W-1 -: OP_W]);
  assign head_fill = head[LW];
  assign head_arg  = head[LW-1:0];

  assign pop       = (state == ST_IDLE) && !queue_empty;
  assign idle      = (state == ST_IDLE) && queue_empty;
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == ST_EMIT) && slot_free;
  assign cnt_inc   = cnt + LW'(1);
  assign more      = (op == OP_DRAIN) && (cnt_inc < len);

  // store read data lands in the cycle after the address and holds until next read
  assign tx_re    = pop && (head_op == OP_REQUEST);
  assign tx_raddr = head_arg[AW-1:0];
  assign rx_re    = (pop && (head_op == OP_DRAIN)) || (emit && more);
  assign rx_raddr = pop ? '0 : cnt_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit && !more) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op   <= head_op;
      fill <= head_fill;
      len  <= head_arg;
      cnt  <= '0;
    end else if (emit && more) begin
      cnt <= cnt_inc;
    end
    if (emit) begin
      case (op)
        OP_REQUEST: begin
          kind       <= KIND_TO_MASTER;
          out_byte   <= fill ? FILL_BYTE : tx_rdata;
          run_last   <= 1'b0;
          run_length <= '0;
          busy_res   <= 1'b1;
        end
        OP_DRAIN: begin
          kind       <= KIND_RX_BYTE;
          out_byte   <= rx_rdata;
          run_last   <= !more;
          run_length <= len;
          busy_res   <= 1'b0;
        end
        default: begin
          kind       <= KIND_TX_DONE;
          out_byte   <= '0;
          run_last   <= 1'b0;
          run_length <= '0;
          busy_res   <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
